>>> src/assert_macros.svh
// Assertion macros used by the matrix norm core.
// Needs a clock named clk and an active-low reset named rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define NRM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define NRM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/nrm_pkg.sv
// Shared types, constants and width helpers of the matrix norm block.
// No dependencies; used by nrm_accum and matrix_norms_stream_core.
package nrm_pkg;

  localparam int DEF_MAX_DIM   = 64;
  localparam int DEF_ELEM_BITS = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 2'd1;

  localparam int OUT_W       = 22;
  localparam int OUT_TDATA_W = 72;
  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  // Control from the sequencer to the accumulator datapath.
  typedef struct packed {
    logic start;
    logic update;
    logic accum;
    logic clear;
    logic first_row;
    logic last_row;
    logic last_col;
  } nrm_ctrl_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_UPD    = 5'b00010,
    ST_ACC    = 5'b00100,
    ST_RSTART = 5'b01000,
    ST_ROOT   = 5'b10000
  } nrm_state_t;

  // A row or column sum of absolute values never exceeds MAX_DIM * 2^(ELEM_BITS-1).
  function automatic int sum_width(input int max_dim, input int elem_bits);
    return elem_bits + $clog2(max_dim);
  endfunction

  // The sum of squares wraps at 64 bits, as a 64-bit accumulator would.
  function automatic int square_width(input int max_dim, input int elem_bits);
    int w;
    w = 2 * elem_bits - 1 + 2 * $clog2(max_dim);
    return (w > 64) ? 64 : w;
  endfunction

endpackage

>>> src/nrm_sqrt.sv
// Iterative floor square root: one result bit per cycle, digit-by-digit method.
// Does not depend on nrm_pkg.
module nrm_sqrt #(
  parameter int SQ_W = 43
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [SQ_W-1:0]         radicand,
  output logic                    busy,
  output logic [(SQ_W+1)/2-1:0]   root
);
  localparam int RT_W    = (SQ_W + 1) / 2;
  localparam int TOP_POS = (SQ_W - 1) - ((SQ_W - 1) % 2);
  localparam logic [SQ_W-1:0] BIT_INIT = SQ_W'(1) << TOP_POS;

  logic [SQ_W-1:0] x_r, x_nxt;
  logic [SQ_W-1:0] res_r, res_nxt;
  logic [SQ_W-1:0] bit_r, bit_nxt;
  logic            busy_r, busy_nxt;
  logic [SQ_W-1:0] trial;

  always_comb begin
    trial    = res_r + bit_r;
    x_nxt    = x_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    if (start) begin
      x_nxt    = radicand;
      res_nxt  = '0;
      bit_nxt  = BIT_INIT;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (x_r >= trial) begin
        x_nxt   = x_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt  = bit_r >> 2;
      busy_nxt = (bit_r >> 2) != '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    x_r   <= x_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign busy = busy_r;
  assign root = res_r[RT_W-1:0];

endmodule

>>> src/nrm_accum.sv
// Accumulator datapath: column sum memory, row sum, sum of squares and best values.
// Depends on nrm_pkg for the control struct, widths and output saturation limit.
module nrm_accum #(
  parameter int MAX_DIM   = nrm_pkg::DEF_MAX_DIM,
  parameter int ELEM_BITS = nrm_pkg::DEF_ELEM_BITS
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  nrm_pkg::nrm_ctrl_t                          ctrl,
  input  logic [$clog2(MAX_DIM)-1:0]                  col_idx,
  input  logic [ELEM_BITS-1:0]                        abs_in,
  output logic [nrm_pkg::OUT_W-1:0]                   norm_one,
  output logic [nrm_pkg::OUT_W-1:0]                   norm_inf,
  output logic [nrm_pkg::square_width(MAX_DIM, ELEM_BITS)-1:0] square_sum
);
  import nrm_pkg::*;

  localparam int SUM_W = sum_width(MAX_DIM, ELEM_BITS);
  localparam int SQ_W  = square_width(MAX_DIM, ELEM_BITS);
  localparam int CW    = (SUM_W > OUT_W) ? SUM_W : OUT_W;

  logic [SUM_W-1:0]       col_mem [MAX_DIM];
  logic [SUM_W-1:0]       rd_r;
  logic [ELEM_BITS-1:0]   a_r;
  logic [2*ELEM_BITS-1:0] prod_r;

  logic [SUM_W-1:0] row_sum_r, row_sum_nxt;
  logic [SUM_W-1:0] best_col_r, best_col_nxt;
  logic [SUM_W-1:0] best_row_r, best_row_nxt;
  logic [SQ_W-1:0]  sq_sum_r, sq_sum_nxt;

  logic [SUM_W-1:0] a_ext;
  logic [SUM_W-1:0] col_new;
  logic [SUM_W-1:0] row_new;
  logic [CW-1:0]    one_ext;
  logic [CW-1:0]    inf_ext;

  assign a_ext = SUM_W'(a_r);

  always_comb begin
    col_new      = ctrl.first_row ? a_ext : rd_r + a_ext;
    row_new      = row_sum_r + a_ext;
    row_sum_nxt  = row_sum_r;
    best_col_nxt = best_col_r;
    best_row_nxt = best_row_r;
    sq_sum_nxt   = sq_sum_r;
    if (ctrl.clear) begin
      row_sum_nxt  = '0;
      best_col_nxt = '0;
      best_row_nxt = '0;
      sq_sum_nxt   = '0;
    end else begin
      if (ctrl.update) begin
        if (ctrl.last_row && (col_new > best_col_r)) begin
          best_col_nxt = col_new;
        end
        if (ctrl.last_col) begin
          if (row_new > best_row_r) begin
            best_row_nxt = row_new;
          end
          row_sum_nxt = '0;
        end else begin
          row_sum_nxt = row_new;
        end
      end
      if (ctrl.accum) begin
        sq_sum_nxt = sq_sum_r + SQ_W'(prod_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_sum_r  <= '0;
      best_col_r <= '0;
      best_row_r <= '0;
      sq_sum_r   <= '0;
    end else begin
      row_sum_r  <= row_sum_nxt;
      best_col_r <= best_col_nxt;
      best_row_r <= best_row_nxt;
      sq_sum_r   <= sq_sum_nxt;
    end
  end

  // The column entry is read when the item is taken and written back in the next cycle, the update state.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      a_r  <= abs_in;
      rd_r <= col_mem[col_idx];
    end
    if (ctrl.update) begin
      col_mem[col_idx] <= col_new;
      prod_r           <= a_r * a_r;
    end
  end

  assign one_ext    = CW'(best_col_r);
  assign inf_ext    = CW'(best_row_r);
  assign norm_one   = (one_ext > CW'(OUT_MAX)) ? OUT_MAX : one_ext[OUT_W-1:0];
  assign norm_inf   = (inf_ext > CW'(OUT_MAX)) ? OUT_MAX : inf_ext[OUT_W-1:0];
  assign square_sum = sq_sum_r;

endmodule

>>> src/matrix_norms_stream_core.sv
// Matrix 1-norm, infinity-norm and Frobenius norm over a stream of row-major elements.
// An element passes through take, column update and square accumulate; in_tready is low until idle again.
// After a matrix's last element the core starts the square root of the sum of squares and loads
// the result when the root is done and the output is free; the root unit gives one bit per cycle.
// Reset (rst_n, synchronous, active low) sets both sizes to 1 and clears row sum, best values and sum of squares.
`include "assert_macros.svh"

module matrix_norms_stream_core #(
  parameter int MAX_DIM   = nrm_pkg::DEF_MAX_DIM,
  parameter int ELEM_BITS = nrm_pkg::DEF_ELEM_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nrm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nrm_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [((ELEM_BITS+7)/8)*8-1:0]    in_tdata,   // element, zero padded
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [nrm_pkg::OUT_TDATA_W-1:0]   out_tdata   // norm_one, norm_infinity,
                                                        // norm_frobenius, zero padded
);
  import nrm_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM);
  localparam int ED_W  = $clog2(MAX_DIM + 1);
  localparam int CMP_W = (ED_W > CFG_DATA_W) ? ED_W : CFG_DATA_W;
  localparam int SQ_W  = square_width(MAX_DIM, ELEM_BITS);
  localparam int RT_W  = (SQ_W + 1) / 2;
  localparam int RCW   = (RT_W > OUT_W) ? RT_W : OUT_W;

  nrm_state_t state_r, state_nxt;
  logic [CFG_DATA_W-1:0] num_rows_r, num_rows_nxt;
  logic [CFG_DATA_W-1:0] num_cols_r, num_cols_nxt;
  logic [DIM_W-1:0]      col_pos_r, col_pos_nxt;
  logic [DIM_W-1:0]      row_pos_r, row_pos_nxt;
  logic                  end_r, end_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic [CMP_W-1:0] rows_ext, cols_ext;
  logic [CMP_W-1:0] eff_rows, eff_cols;
  logic             last_row, last_col;
  logic [ELEM_BITS-1:0] elem, elem_abs;
  logic             cfg_hit;
  logic             rt_start, rt_busy;
  logic             out_load;
  logic [RT_W-1:0]  root;
  logic [RCW-1:0]   root_ext;
  logic [OUT_W-1:0] norm_one, norm_inf, norm_frob;
  logic [SQ_W-1:0]  square_sum;
  nrm_ctrl_t        ctrl;

  // Size registers: zero means one, anything above MAX_DIM means MAX_DIM.
  always_comb begin
    rows_ext = CMP_W'(num_rows_r);
    cols_ext = CMP_W'(num_cols_r);
    if (rows_ext == '0) begin
      eff_rows = CMP_W'(1);
    end else if (rows_ext > CMP_W'(MAX_DIM)) begin
      eff_rows = CMP_W'(MAX_DIM);
    end else begin
      eff_rows = rows_ext;
    end
    if (cols_ext == '0) begin
      eff_cols = CMP_W'(1);
    end else if (cols_ext > CMP_W'(MAX_DIM)) begin
      eff_cols = CMP_W'(MAX_DIM);
    end else begin
      eff_cols = cols_ext;
    end
  end

  assign last_row = (CMP_W'(row_pos_r) + CMP_W'(1)) >= eff_rows;
  assign last_col = (CMP_W'(col_pos_r) + CMP_W'(1)) >= eff_cols;

  // The most negative element maps to 2^(ELEM_BITS-1), which still fits unsigned.
  assign elem     = in_tdata[ELEM_BITS-1:0];
  assign elem_abs = elem[ELEM_BITS-1] ? (~elem + ELEM_BITS'(1)) : elem;

  assign cfg_ready = 1'b1;

  always_comb begin
    num_rows_nxt = num_rows_r;
    num_cols_nxt = num_cols_r;
    cfg_hit      = 1'b0;
    if (cfg_valid) begin
      case (cfg_index)
        REG_NUM_ROWS: begin
          num_rows_nxt = cfg_data;
          cfg_hit      = 1'b1;
        end
        REG_NUM_COLS: begin
          num_cols_nxt = cfg_data;
          cfg_hit      = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    col_pos_nxt    = col_pos_r;
    row_pos_nxt    = row_pos_r;
    end_nxt        = end_r;
    rt_start       = 1'b0;
    out_load       = 1'b0;
    ctrl           = '0;
    ctrl.first_row = (row_pos_r == '0);
    ctrl.last_row  = last_row;
    ctrl.last_col  = last_col;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          ctrl.start = 1'b1;
          state_nxt  = ST_UPD;
        end
      end
      ST_UPD: begin
        ctrl.update = 1'b1;
        end_nxt     = last_row && last_col;
        if (last_col) begin
          col_pos_nxt = '0;
          row_pos_nxt = last_row ? '0 : row_pos_r + DIM_W'(1);
        end else begin
          col_pos_nxt = col_pos_r + DIM_W'(1);
        end
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        ctrl.accum = 1'b1;
        state_nxt  = end_r ? ST_RSTART : ST_IDLE;
      end
      ST_RSTART: begin
        rt_start  = 1'b1;
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        // Wait for the root and for a free output register.
        if (!rt_busy && (!out_tvalid_r || out_tready)) begin
          out_load   = 1'b1;
          ctrl.clear = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (cfg_hit) begin
      ctrl.clear  = 1'b1;
      col_pos_nxt = '0;
      row_pos_nxt = '0;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  nrm_accum #(
    .MAX_DIM   (MAX_DIM),
    .ELEM_BITS (ELEM_BITS)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .col_idx    (col_pos_r),
    .abs_in     (elem_abs),
    .norm_one   (norm_one),
    .norm_inf   (norm_inf),
    .square_sum (square_sum)
  );

  nrm_sqrt #(
    .SQ_W (SQ_W)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rt_start),
    .radicand (square_sum),
    .busy     (rt_busy),
    .root     (root)
  );

  assign root_ext  = RCW'(root);
  assign norm_frob = (root_ext > RCW'(OUT_MAX)) ? OUT_MAX : root_ext[OUT_W-1:0];

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    if (out_load) begin
      out_tvalid_nxt                      = 1'b1;
      out_tdata_nxt                       = '0;
      out_tdata_nxt[OUT_W-1:0]            = norm_one;
      out_tdata_nxt[2*OUT_W-1:OUT_W]      = norm_inf;
      out_tdata_nxt[3*OUT_W-1:2*OUT_W]    = norm_frob;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      num_rows_r   <= CFG_DATA_W'(1);
      num_cols_r   <= CFG_DATA_W'(1);
      col_pos_r    <= '0;
      row_pos_r    <= '0;
      end_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      num_rows_r   <= num_rows_nxt;
      num_cols_r   <= num_cols_nxt;
      col_pos_r    <= col_pos_nxt;
      row_pos_r    <= row_pos_nxt;
      end_r        <= end_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `NRM_ASSERT(a_busy_after_take, (in_tvalid && in_tready) |=> !in_tready, "input ready right after an item")
  `NRM_ASSERT(a_root_in_root_state, rt_busy |-> (state_r == ST_ROOT), "root unit busy outside root wait")
  `NRM_ASSERT(a_result_after_root, $rose(out_tvalid_r) |-> $past(state_r == ST_ROOT), "result not from root wait")
  `NRM_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> ((state_r == ST_IDLE) && !out_tvalid_r), "reset not idle")

endmodule
